/* design/qaom_pkg.sv */
`timescale 1ns / 1ps
// qaom_pkg: shared types, constants and helpers for the quaternion axis order matcher.
// No dependencies.
package qaom_pkg;

    typedef logic [1:0] idx_t;
    typedef logic [2:0] perm_t;

    localparam int NUM_PERM = 6;

    localparam perm_t PERM_012 = 3'd0;
    localparam perm_t PERM_021 = 3'd1;
    localparam perm_t PERM_102 = 3'd2;
    localparam perm_t PERM_120 = 3'd3;
    localparam perm_t PERM_201 = 3'd4;
    localparam perm_t PERM_210 = 3'd5;

    localparam idx_t REG_AXIS_A  = 2'd0;
    localparam idx_t REG_AXIS_B  = 2'd1;
    localparam idx_t REG_AXIS_C  = 2'd2;
    localparam idx_t REG_PERMUTE = 2'd3;

    localparam logic [47:0] AXIS_A_RESET = 48'h0000_0000_4000;
    localparam logic [47:0] AXIS_B_RESET = 48'h0000_4000_0000;
    localparam logic [47:0] AXIS_C_RESET = 48'h4000_0000_0000;

    // rotated axis component width (signed, 2F fraction bits)
    function automatic int axis_width(input int frac);
        return (2 * frac + 3 > 35) ? 2 * frac + 3 : 35;
    endfunction

    // alignment magnitude width (unsigned, 3F fraction bits)
    function automatic int align_width(input int frac);
        return axis_width(frac) + 18;
    endfunction

    // reference index picked for rotated axis i (bits 2i+1:2i)
    function automatic logic [5:0] perm_picks(input perm_t p);
        logic [5:0] r;
        unique case (p)
            PERM_012: r = {2'd2, 2'd1, 2'd0};
            PERM_021: r = {2'd1, 2'd2, 2'd0};
            PERM_102: r = {2'd2, 2'd0, 2'd1};
            PERM_120: r = {2'd0, 2'd2, 2'd1};
            PERM_201: r = {2'd1, 2'd0, 2'd2};
            PERM_210: r = {2'd0, 2'd1, 2'd2};
            default:  r = {2'd2, 2'd1, 2'd0};
        endcase
        return r;
    endfunction

endpackage

/* design/qaom_align.sv */
`timescale 1ns / 1ps
// qaom_align: four-stage pipeline from quaternion to the 3x3 absolute alignment matrix.
// Depends on qaom_pkg.
module qaom_align #(
    parameter int FRAC_BITS = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] quat,      // w, x, y, z from bit 0 up
    input  logic [47:0] ref_a,
    input  logic [47:0] ref_b,
    input  logic [47:0] ref_c,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0][2:0][qaom_pkg::align_width(FRAC_BITS)-1:0] align
);
    import qaom_pkg::*;

    localparam int AW = axis_width(FRAC_BITS);
    localparam int DW = AW + 16;
    localparam int SW = AW + 18;
    localparam int MW = align_width(FRAC_BITS);
    localparam logic signed [AW-1:0] ONE = {{(AW-1){1'b0}}, 1'b1} << (2 * FRAC_BITS);

    logic [3:0] valid_reg;
    logic [3:0] en;

    logic signed [31:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    logic signed [AW-1:0] axis_reg [3][3];
    logic signed [AW-1:0] axis_next [3][3];
    logic signed [DW-1:0] mult_reg [3][3][3];
    logic signed [15:0]   refc [3][3];
    logic [2:0][2:0][MW-1:0] align_reg;
    logic [2:0][2:0][MW-1:0] align_next;

    logic signed [15:0] qw, qx, qy, qz;

    assign qw = signed'(quat[15:0]);
    assign qx = signed'(quat[31:16]);
    assign qy = signed'(quat[47:32]);
    assign qz = signed'(quat[63:48]);

    assign en[3] = !valid_reg[3] || out_ready;
    assign en[2] = !valid_reg[2] || en[3];
    assign en[1] = !valid_reg[1] || en[2];
    assign en[0] = !valid_reg[0] || en[1];
    assign in_ready  = en[0];
    assign out_valid = valid_reg[3];
    assign align     = align_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0]) valid_reg[0] <= in_valid;
            if (en[1]) valid_reg[1] <= valid_reg[0];
            if (en[2]) valid_reg[2] <= valid_reg[1];
            if (en[3]) valid_reg[3] <= valid_reg[2];
        end
    end

    // stage 1: pairwise products
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            xx_reg <= 32'(qx) * 32'(qx);
            yy_reg <= 32'(qy) * 32'(qy);
            zz_reg <= 32'(qz) * 32'(qz);
            xy_reg <= 32'(qx) * 32'(qy);
            xz_reg <= 32'(qx) * 32'(qz);
            yz_reg <= 32'(qy) * 32'(qz);
            wx_reg <= 32'(qw) * 32'(qx);
            wy_reg <= 32'(qw) * 32'(qy);
            wz_reg <= 32'(qw) * 32'(qz);
        end
    end

    // stage 2: rotated basis axes
    always_comb
    begin
        axis_next[0][0] = ONE - ((AW'(yy_reg) + AW'(zz_reg)) <<< 1);
        axis_next[0][1] = (AW'(xy_reg) + AW'(wz_reg)) <<< 1;
        axis_next[0][2] = (AW'(xz_reg) - AW'(wy_reg)) <<< 1;
        axis_next[1][0] = (AW'(xy_reg) - AW'(wz_reg)) <<< 1;
        axis_next[1][1] = ONE - ((AW'(xx_reg) + AW'(zz_reg)) <<< 1);
        axis_next[1][2] = (AW'(yz_reg) + AW'(wx_reg)) <<< 1;
        axis_next[2][0] = (AW'(xz_reg) + AW'(wy_reg)) <<< 1;
        axis_next[2][1] = (AW'(yz_reg) - AW'(wx_reg)) <<< 1;
        axis_next[2][2] = ONE - ((AW'(xx_reg) + AW'(yy_reg)) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            axis_reg <= axis_next;
        end
    end

    // stage 3: component products against the reference axes
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            refc[0][k] = signed'(ref_a[16*k +: 16]);
            refc[1][k] = signed'(ref_b[16*k +: 16]);
            refc[2][k] = signed'(ref_c[16*k +: 16]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    for (int k = 0; k < 3; k++)
                        mult_reg[i][j][k] <= DW'(axis_reg[i][k]) * DW'(refc[j][k]);
        end
    end

    // stage 4: dot product and magnitude
    always_comb
    begin
        logic signed [SW-1:0] dot;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                dot = SW'(mult_reg[i][j][0]) + SW'(mult_reg[i][j][1])
                    + SW'(mult_reg[i][j][2]);
                align_next[i][j] = dot[SW-1] ? MW'(-dot) : MW'(dot);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            align_reg <= align_next;
        end
    end

endmodule

/* design/quat_axis_order_matcher.sv */
`timescale 1ns / 1ps
// quat_axis_order_matcher: top level, APB register file, axis selection pipeline.
// Depends on qaom_pkg and qaom_align.
//
// Usage:
//   s_axis carries one quaternion per word (w, x, y, z, Q2.14). m_axis returns
//   one word per quaternion: the reference axis index matched to each rotated
//   basis axis. The APB port holds the three reference axes and permute_mode
//   at byte addresses 0, 8, 16, 24; write them only while the block is empty.
//   Four stages build the alignment matrix (products, axes, axis-by-reference
//   products, sums), three pick the result (scores, pair compare, final
//   compare). Throughput is one word per cycle while m_axis_tready is high;
//   every stage is a register with its own valid bit.
//   Each stage loads when it is empty or the stage after it moves, so bubbles
//   are squeezed out and a stalled m_axis_tready holds the pipe without loss.
//   Reset clears all valid bits and loads the reference axes with x, y and z
//   unit vectors and permute_mode with 0.
module quat_axis_order_matcher #(
    parameter int FRAC_BITS = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // quat_w, quat_x, quat_y, quat_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // first_match_res, second_match, third_match, pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import qaom_pkg::*;

    localparam int MW = align_width(FRAC_BITS);
    localparam int SCW = MW + 2;

    logic [47:0] ref_a_reg, ref_b_reg, ref_c_reg;
    logic        permute_mode_reg;
    idx_t        reg_idx;

    logic                    align_valid;
    logic                    align_ready;
    logic [2:0][2:0][MW-1:0] align;

    logic [2:0]     valid_reg;
    logic [2:0]     en;
    logic           mode1_reg, mode2_reg;
    logic [SCW-1:0] score_reg [NUM_PERM];
    logic [SCW-1:0] score_next [NUM_PERM];
    logic [5:0]     ind1_reg, ind2_reg;
    logic [5:0]     ind_next;
    logic [SCW-1:0] pair_score_reg [3];
    perm_t          pair_perm_reg [3];
    logic [5:0]     result_reg;
    logic [5:0]     result_next;

    // configuration
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_a_reg        <= AXIS_A_RESET;
            ref_b_reg        <= AXIS_B_RESET;
            ref_c_reg        <= AXIS_C_RESET;
            permute_mode_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_idx)
                REG_AXIS_A:  ref_a_reg        <= pwdata[47:0];
                REG_AXIS_B:  ref_b_reg        <= pwdata[47:0];
                REG_AXIS_C:  ref_c_reg        <= pwdata[47:0];
                REG_PERMUTE: permute_mode_reg <= pwdata[0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_AXIS_A:  prdata = {16'd0, ref_a_reg};
            REG_AXIS_B:  prdata = {16'd0, ref_b_reg};
            REG_AXIS_C:  prdata = {16'd0, ref_c_reg};
            REG_PERMUTE: prdata = {63'd0, permute_mode_reg};
            default:     prdata = '0;
        endcase
    end

    qaom_align #(
        .FRAC_BITS (FRAC_BITS)
    ) u_align (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .quat      (s_axis_tdata),
        .ref_a     (ref_a_reg),
        .ref_b     (ref_b_reg),
        .ref_c     (ref_c_reg),
        .out_valid (align_valid),
        .out_ready (align_ready),
        .align     (align)
    );

    // selection pipeline control
    assign en[2] = !valid_reg[2] || m_axis_tready;
    assign en[1] = !valid_reg[1] || en[2];
    assign en[0] = !valid_reg[0] || en[1];
    assign align_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0]) valid_reg[0] <= align_valid;
            if (en[1]) valid_reg[1] <= valid_reg[0];
            if (en[2]) valid_reg[2] <= valid_reg[1];
        end
    end

    // stage 1: permutation scores and independent picks
    always_comb
    begin
        logic [5:0] pk;
        for (int p = 0; p < NUM_PERM; p++)
        begin
            pk = perm_picks(perm_t'(p));
            score_next[p] = SCW'(align[0][pk[1:0]]) + SCW'(align[1][pk[3:2]])
                          + SCW'(align[2][pk[5:4]]);
        end
        for (int i = 0; i < 3; i++)
        begin
            if (align[i][0] >= align[i][1] && align[i][0] >= align[i][2])
                ind_next[2*i +: 2] = 2'd0;
            else if (align[i][1] >= align[i][2])
                ind_next[2*i +: 2] = 2'd1;
            else
                ind_next[2*i +: 2] = 2'd2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            score_reg <= score_next;
            ind1_reg  <= ind_next;
            mode1_reg <= permute_mode_reg;
        end
    end

    // stage 2: best of each pair, earlier wins ties
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int g = 0; g < 3; g++)
            begin
                if (score_reg[2*g+1] > score_reg[2*g])
                begin
                    pair_score_reg[g] <= score_reg[2*g+1];
                    pair_perm_reg[g]  <= perm_t'(2*g+1);
                end
                else
                begin
                    pair_score_reg[g] <= score_reg[2*g];
                    pair_perm_reg[g]  <= perm_t'(2*g);
                end
            end
            ind2_reg  <= ind1_reg;
            mode2_reg <= mode1_reg;
        end
    end

    // stage 3: final pick
    always_comb
    begin
        perm_t          best;
        logic [SCW-1:0] best_score;
        best       = pair_perm_reg[0];
        best_score = pair_score_reg[0];
        if (pair_score_reg[1] > best_score)
        begin
            best       = pair_perm_reg[1];
            best_score = pair_score_reg[1];
        end
        if (pair_score_reg[2] > best_score)
        begin
            best = pair_perm_reg[2];
        end
        result_next = mode2_reg ? perm_picks(best) : ind2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = valid_reg[2];
    assign m_axis_tdata  = {2'b00, result_reg};

    // a moving output never blocks the input side
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output moves");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3 && m_axis_tdata[3:2] != 2'd3
                           && m_axis_tdata[5:4] != 2'd3))
        else $error("match index out of range");

    a_perm_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && permute_mode_reg) |->
            (m_axis_tdata[1:0] != m_axis_tdata[3:2] && m_axis_tdata[1:0] != m_axis_tdata[5:4]
             && m_axis_tdata[3:2] != m_axis_tdata[5:4]))
        else $error("permute mode result is not a permutation");

    a_align_held: assert property (@(posedge clk) disable iff (!rst_n)
        (align_valid && !align_ready) |=> (align_valid && $stable(align)))
        else $error("alignment matrix changed while stalled");

endmodule
